>>> design/poc_pkg.sv
// poc_pkg: shared types and constants for the permutation order crossover block
// used by poc_front, poc_fifo, poc_back and permutation_order_crossover
package poc_pkg;

  localparam int MAX_GENES   = 32;
  localparam int ID_SPACE    = 1024;
  localparam int ID_W        = 10;
  localparam int ROT_W       = 16;
  localparam int FRAC_W      = 16;
  localparam int GENE_AW     = $clog2(MAX_GENES);
  localparam int CNT_W       = GENE_AW + 1;
  localparam int SEEN_AW     = $clog2(ID_SPACE);
  localparam int JOB_W       = 7;
  localparam int MARK_W      = JOB_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;
  localparam int PROD_W      = FRAC_W + GENE_AW;

  localparam logic [FRAC_W-1:0] FRAC_LO   = FRAC_W'(6554);
  localparam logic [FRAC_W-1:0] FRAC_HI   = FRAC_W'(58982);
  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(32768);

  typedef struct packed {
    logic [ID_W-1:0]   part_id_a;
    logic [ROT_W-1:0]  rotation_a;
    logic [ID_W-1:0]   part_id_b;
    logic [ROT_W-1:0]  rotation_b;
    logic [FRAC_W-1:0] cut_fraction;
    logic              is_last;
  } poc_in_t;

  typedef struct packed {
    logic              child_select;
    logic [ID_W-1:0]   part_id;
    logic [ROT_W-1:0]  rotation;
    logic              end_of_children;
  } poc_out_t;

  typedef struct packed {
    logic [ID_W-1:0]  part_id;
    logic [ROT_W-1:0] rotation;
  } poc_gene_t;

  typedef struct packed {
    logic               store;
    logic               run;
    logic [GENE_AW-1:0] slot;
    poc_gene_t          gene_a;
    poc_gene_t          gene_b;
    logic [CNT_W-1:0]   n;
    logic [GENE_AW-1:0] cut;
  } poc_cmd_t;

endpackage

>>> design/poc_front.sv
// poc_front: accepts input words, tracks the load count and turns each word
// into a command (store slot, run flag, gene count and cut point); uses poc_pkg
module poc_front
  import poc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  poc_in_t  in_word_i,
  output logic     cmd_vld_o,
  output poc_cmd_t cmd_o
);

  logic [CNT_W-1:0]   cnt_q;
  logic               store;
  logic [CNT_W-1:0]   n_after;
  logic [GENE_AW-1:0] n_m1;
  logic [FRAC_W-1:0]  frac_c;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  rounded;

  assign store   = (cnt_q < CNT_W'(MAX_GENES));
  assign n_after = cnt_q + CNT_W'(store);
  assign n_m1    = GENE_AW'(n_after - CNT_W'(1));

  always_comb begin
    if (in_word_i.cut_fraction < FRAC_LO) begin
      frac_c = FRAC_LO;
    end else if (in_word_i.cut_fraction > FRAC_HI) begin
      frac_c = FRAC_HI;
    end else begin
      frac_c = in_word_i.cut_fraction;
    end
  end

  assign prod    = PROD_W'(frac_c) * PROD_W'(n_m1);
  assign rounded = prod + ROUND_ADD;

  always_comb begin
    cmd_o.store           = store;
    cmd_o.run             = in_word_i.is_last;
    cmd_o.slot            = cnt_q[GENE_AW-1:0];
    cmd_o.gene_a.part_id  = in_word_i.part_id_a;
    cmd_o.gene_a.rotation = in_word_i.rotation_a;
    cmd_o.gene_b.part_id  = in_word_i.part_id_b;
    cmd_o.gene_b.rotation = in_word_i.rotation_b;
    cmd_o.n               = n_after;
    cmd_o.cut             = rounded[PROD_W-1:FRAC_W];
  end

  assign cmd_vld_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      if (in_word_i.is_last) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= n_after;
      end
    end
  end

endmodule

>>> design/poc_fifo.sv
// poc_fifo: short command queue between the front and back parts
// depth from poc_pkg::QUEUE_DEPTH; uses poc_pkg
module poc_fifo
  import poc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  poc_cmd_t wr_word_i,
  output logic     full_o,
  output logic     rd_vld_o,
  output poc_cmd_t rd_word_o,
  input  logic     pop_i
);

  poc_cmd_t            mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q;
  logic [QUEUE_AW-1:0] rd_ptr_q;
  logic [QUEUE_CW-1:0] cnt_q;
  logic                do_wr;
  logic                do_rd;

  assign full_o    = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign rd_vld_o  = (cnt_q != '0);
  assign rd_word_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = pop_i && rd_vld_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + QUEUE_CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - QUEUE_CW'(1);
      end
    end
  end

endmodule

>>> design/poc_back.sv
// poc_back: stores parent genes, builds both children with an epoch-marked
// seen memory and drives the output word register; uses poc_pkg
module poc_back
  import poc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_vld_i,
  input  poc_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     clearing_o,
  output logic     empty_o,
  output poc_out_t out_word_o,
  input  logic     pop_i
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRE_RD,
    ST_PRE_EMIT,
    ST_FIL_RD,
    ST_FIL_CHK,
    ST_FIL_DEC,
    ST_CHILD_END,
    ST_FLUSH
  } state_e;

  state_e             state_q;
  logic [SEEN_AW-1:0] clr_q;
  logic [JOB_W-1:0]   job_q;
  logic               sel_q;
  logic [CNT_W-1:0]   idx_q;
  logic [CNT_W-1:0]   len_q;
  logic [CNT_W-1:0]   n_q;
  logic [GENE_AW-1:0] cut_q;
  poc_out_t           hold_q;
  logic               hold_vld_q;
  poc_out_t           out_q;
  logic               out_vld_q;

  poc_gene_t          mem_a [MAX_GENES];
  poc_gene_t          mem_b [MAX_GENES];
  logic [MARK_W-1:0]  seen_mem [ID_SPACE];
  poc_gene_t          rd_a_q;
  poc_gene_t          rd_b_q;
  logic [MARK_W-1:0]  seen_rd_q;

  logic [GENE_AW-1:0] rd_idx;
  poc_gene_t          pre_gene;
  poc_gene_t          fill_gene;
  logic [MARK_W-1:0]  mark;
  logic               seen_hit;
  logic               out_ready;
  logic               emit_ok;
  logic               out_load;
  poc_out_t           emit_word;
  poc_out_t           flush_word;
  logic               gene_we;
  logic               seen_we;
  logic [SEEN_AW-1:0] seen_wa;
  logic [MARK_W-1:0]  seen_wd;

  assign rd_idx     = idx_q[GENE_AW-1:0];
  assign pre_gene   = sel_q ? rd_b_q : rd_a_q;
  assign fill_gene  = sel_q ? rd_a_q : rd_b_q;
  assign mark       = {job_q, sel_q};
  assign seen_hit   = (seen_rd_q == mark);
  assign out_ready  = !out_vld_q || pop_i;
  assign emit_ok    = !hold_vld_q || out_ready;
  assign out_load   = hold_vld_q && out_ready &&
                      ((state_q == ST_PRE_EMIT) ||
                       ((state_q == ST_FIL_DEC) && !seen_hit) ||
                       (state_q == ST_FLUSH));
  assign gene_we    = (state_q == ST_IDLE) && cmd_vld_i && cmd_i.store;
  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_vld_i;
  assign clearing_o = (state_q == ST_CLEAR);
  assign empty_o    = !out_vld_q;
  assign out_word_o = out_q;

  always_comb begin
    emit_word.child_select    = sel_q;
    emit_word.part_id         = (state_q == ST_PRE_EMIT) ? pre_gene.part_id : fill_gene.part_id;
    emit_word.rotation        = (state_q == ST_PRE_EMIT) ? pre_gene.rotation : fill_gene.rotation;
    emit_word.end_of_children = 1'b0;
    flush_word                = hold_q;
    flush_word.end_of_children = 1'b1;
  end

  always_comb begin
    seen_we = 1'b0;
    seen_wa = fill_gene.part_id;
    seen_wd = mark;
    unique case (state_q)
      ST_CLEAR: begin
        seen_we = 1'b1;
        seen_wa = clr_q;
        seen_wd = '0;
      end
      ST_PRE_EMIT: begin
        seen_we = emit_ok;
        seen_wa = pre_gene.part_id;
      end
      ST_FIL_DEC: begin
        seen_we = emit_ok && !seen_hit;
      end
      default: begin
        seen_we = 1'b0;
      end
    endcase
  end

  // parent gene store, read every cycle at the walk index
  always_ff @(posedge clk_i) begin
    if (gene_we) begin
      mem_a[cmd_i.slot] <= cmd_i.gene_a;
      mem_b[cmd_i.slot] <= cmd_i.gene_b;
    end
    rd_a_q <= mem_a[rd_idx];
    rd_b_q <= mem_b[rd_idx];
  end

  // seen marks, one per identifier
  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_rd_q <= seen_mem[fill_gene.part_id];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      job_q      <= JOB_W'(1);
      sel_q      <= 1'b0;
      idx_q      <= '0;
      len_q      <= '0;
      n_q        <= '0;
      cut_q      <= '0;
      hold_q     <= '0;
      hold_vld_q <= 1'b0;
      out_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (pop_i && out_vld_q) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SEEN_AW'(1);
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_vld_i && cmd_i.run) begin
            n_q     <= cmd_i.n;
            cut_q   <= cmd_i.cut;
            sel_q   <= 1'b0;
            idx_q   <= '0;
            len_q   <= '0;
            state_q <= (cmd_i.cut != '0) ? ST_PRE_RD : ST_FIL_RD;
          end
        end
        ST_PRE_RD: begin
          state_q <= ST_PRE_EMIT;
        end
        ST_PRE_EMIT: begin
          if (emit_ok) begin
            if (hold_vld_q) begin
              out_q <= hold_q;
            end
            hold_q     <= emit_word;
            hold_vld_q <= 1'b1;
            len_q      <= len_q + CNT_W'(1);
            if (idx_q + CNT_W'(1) == CNT_W'(cut_q)) begin
              idx_q   <= '0;
              state_q <= ST_FIL_RD;
            end else begin
              idx_q   <= idx_q + CNT_W'(1);
              state_q <= ST_PRE_RD;
            end
          end
        end
        ST_FIL_RD: begin
          if (idx_q == n_q || len_q == n_q) begin
            state_q <= ST_CHILD_END;
          end else begin
            state_q <= ST_FIL_CHK;
          end
        end
        ST_FIL_CHK: begin
          state_q <= ST_FIL_DEC;
        end
        ST_FIL_DEC: begin
          if (seen_hit) begin
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= ST_FIL_RD;
          end else if (emit_ok) begin
            if (hold_vld_q) begin
              out_q <= hold_q;
            end
            hold_q     <= emit_word;
            hold_vld_q <= 1'b1;
            len_q      <= len_q + CNT_W'(1);
            idx_q      <= idx_q + CNT_W'(1);
            state_q    <= ST_FIL_RD;
          end
        end
        ST_CHILD_END: begin
          if (!sel_q) begin
            sel_q   <= 1'b1;
            idx_q   <= '0;
            len_q   <= '0;
            state_q <= (cut_q != '0) ? ST_PRE_RD : ST_FIL_RD;
          end else begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!hold_vld_q || out_ready) begin
            if (hold_vld_q) begin
              out_q <= flush_word;
            end
            hold_vld_q <= 1'b0;
            sel_q      <= 1'b0;
            // marks wrap: sweep the seen memory before reuse
            if (job_q == '1) begin
              job_q   <= JOB_W'(1);
              clr_q   <= '0;
              state_q <= ST_CLEAR;
            end else begin
              job_q   <= job_q + JOB_W'(1);
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !hold_vld_q)
    else $error("word left in hold stage at job end");

  a_prefix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PRE_EMIT |-> idx_q < CNT_W'(cut_q))
    else $error("prefix walk past cut point");

  a_fill_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIL_DEC |-> len_q < n_q)
    else $error("child grew past gene count");

  a_flush_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> sel_q && hold_vld_q)
    else $error("flush without a second child word");
`endif

endmodule

>>> design/permutation_order_crossover.sv
// permutation_order_crossover: top level, single point order crossover
// instantiates poc_front, poc_fifo and poc_back; uses poc_pkg
//
// Input channel (push/full): one word per gene position, both parents side by
// side; the word with is_last set starts the job and carries the cut fraction.
// Loading takes one word per cycle while full is low; positions past 32 are dropped.
// Output channel (empty/pop): child one's genes, then child two's, one word
// each; end_of_children marks the last word of child two.
// A short command queue parts loading from child building, so up to four words
// of the next job are taken while the current job is still emitted.
// Child building walks the gene store one position at a time: each prefix gene
// passes ST_PRE_RD and ST_PRE_EMIT, each scanned fill gene ST_FIL_RD, ST_FIL_CHK
// and ST_FIL_DEC (gene read, then seen-memory read); each child ends in
// ST_CHILD_END and each job in ST_FLUSH.
// The last word of a job is held back in the hold stage until child two is complete.
// After reset every entry of the seen memory is cleared with full high; the
// same sweep runs once after every 127 jobs.
// A stalled receiver (pop low) holds the oldest word on out_word_o and stalls
// child building at the next emit once the output and hold stages are occupied.
module permutation_order_crossover
  import poc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  poc_in_t  in_word_i,
  output logic     empty,
  input  logic     pop,
  output poc_out_t out_word_o
);

  logic     accept;
  logic     cmd_vld;
  poc_cmd_t cmd;
  logic     q_full;
  logic     q_vld;
  poc_cmd_t q_word;
  logic     q_pop;
  logic     clearing;

  assign full   = q_full || clearing;
  assign accept = push && !full;

  poc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .cmd_vld_o (cmd_vld),
    .cmd_o     (cmd)
  );

  poc_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_vld),
    .wr_word_i (cmd),
    .full_o    (q_full),
    .rd_vld_o  (q_vld),
    .rd_word_o (q_word),
    .pop_i     (q_pop)
  );

  poc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (q_vld),
    .cmd_i      (q_word),
    .cmd_pop_o  (q_pop),
    .clearing_o (clearing),
    .empty_o    (empty),
    .out_word_o (out_word_o),
    .pop_i      (pop)
  );

endmodule
